/* rtl/core/epoch_seconds_to_date_defines.svh */
// Assertion helpers for the date converter.
`ifndef EPOCH_SECONDS_TO_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_DATE_DEFINES_SVH
// Assert that cond implies nxt in the following cycle, reset aware.
`define ESD_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
// Assert that a condition holds at every edge, reset aware.
`define ESD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

/* rtl/core/esd_pkg.sv */
`default_nettype none
package esd_pkg;
  localparam int unsigned EpochYear = 1970;
  localparam int unsigned EpochWeekday = 3;
  localparam int unsigned DaysW = 16;
  localparam int unsigned QuadDays = 1461;

  // Reciprocals: 86400 = 675 << 7, so seconds >> 7 is divided by 675.
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam int unsigned DayShift = 35;
  localparam logic [16:0] QuadRecip = 17'd91868;
  localparam int unsigned QuadShift = 27;
  localparam logic [17:0] WeekRecip = 18'd149797;
  localparam int unsigned WeekShift = 20;

  // Third year of each four-year block (1972, 1976, ...) is the leap year.
  localparam logic [1:0] LeapSlot = 2'd2;

  // Day of year on which month m starts, counted from 0.
  function automatic logic [8:0] month_first(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (leap && m >= 4'd3) r = r + 9'd1;
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/epoch_seconds_to_date.sv */
// Epoch seconds to civil date converter.
// Input channel: drive epoch_seconds with start high; the beat is taken at
// every rising edge where start is high and busy is low. Busy is high only
// while rst is asserted, so a beat can enter on any cycle after reset.
// Result channel: year, month, day_of_month and weekday stand on their ports
// for exactly one cycle with done high; the receiver cannot stall, so the
// pipeline never holds and nothing backs up.
// Six register stages, each with constant multiplies, subtractions or a short compare chain:
//   1. whole days = seconds / 86400 by reciprocal multiply
//   2. four-year block and weekday quotients by reciprocal multiply
//   3. day within the block and weekday remainder
//   4. year within the block and day of year
//   5. month from the table of first days
//   6. day of month into the result registers, done raised
// Done is registered from the stage five valid bit and rises together with
// the result registers; the receiver takes the result while done is high.
// Throughput: one beat per cycle, back to back.
// Reset (rst, synchronous) clears the valid bits and drops items in flight;
// no result is shown for them. Leap years are every fourth year, exact
// through 2099; the top input gives 2106-02-06.
`default_nettype none
`include "epoch_seconds_to_date_defines.svh"
module epoch_seconds_to_date
  import esd_pkg::*;
(
  input  wire  logic        clk,
  input  wire  logic        rst,
  input  wire  logic        start,
  input  wire  logic [31:0] epoch_seconds,
  output logic              busy,
  output logic              done,
  output logic [11:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [2:0]        weekday
);
  // stage valid bits
  logic v1, v2, v3, v4, v5;

  // stage registers
  logic [DaysW-1:0] days1;
  logic [DaysW-1:0] days2;
  logic [5:0]  quad2;
  logic [16:0] wk_t2;
  logic [14:0] wk_q2;
  logic [5:0]  quad3;
  logic [10:0] qrem3;
  logic [2:0]  wd3;
  logic [11:0] yr4;
  logic [8:0]  doy4;
  logic        leap4;
  logic [2:0]  wd4;
  logic [11:0] yr5;
  logic [8:0]  doy5;
  logic        leap5;
  logic [3:0]  mon5;
  logic [2:0]  wd5;

  // combinational paths between stages
  logic [50:0] day_prod;
  logic [32:0] quad_prod;
  logic [16:0] wk_t;
  logic [34:0] wk_prod;
  logic [16:0] quad_base;
  logic [16:0] block_day;
  logic [16:0] wk_base;
  logic [16:0] wk_rem;
  logic [1:0]  yoff;
  logic [10:0] ystart;
  logic [10:0] doy_w;
  logic [3:0]  mon_w;
  logic [8:0]  dom_off;

  // Stage 1 input: drop seven bits, divide by 675.
  assign day_prod = 51'(epoch_seconds[31:7]) * 51'(DayRecip);

  // Stage 2 input: block of four years and weekday quotient.
  assign quad_prod = 33'(days1) * 33'(QuadRecip);
  assign wk_t      = 17'(days1) + 17'(EpochWeekday);
  assign wk_prod   = 35'(wk_t) * 35'(WeekRecip);

  // Stage 3 input: remainders.
  assign quad_base = 17'(quad2) * 17'(QuadDays);
  assign block_day = 17'(days2) - quad_base;
  assign wk_base   = 17'(wk_q2) * 17'd7;
  assign wk_rem    = wk_t2 - wk_base;

  // Stage 4 input: peel whole years off the block (365, 365, 366, 365).
  always_comb begin
    if (qrem3 >= 11'd1096) begin
      yoff   = 2'd3;
      ystart = 11'd1096;
    end else if (qrem3 >= 11'd730) begin
      yoff   = 2'd2;
      ystart = 11'd730;
    end else if (qrem3 >= 11'd365) begin
      yoff   = 2'd1;
      ystart = 11'd365;
    end else begin
      yoff   = 2'd0;
      ystart = 11'd0;
    end
  end
  assign doy_w = qrem3 - ystart;

  // Stage 5 input: last month whose first day is not past the day of year.
  always_comb begin
    mon_w = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (doy4 >= month_first(4'(m), leap4)) mon_w = 4'(m);
    end
  end

  // Stage 6 input: offset into the month.
  assign dom_off = doy5 - month_first(mon5, leap5);

  // Hold off beats only while reset drops the pipeline.
  assign busy = rst;

  // Advance the valid bits; drop everything on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Advance the data; the result registers load only with a valid beat.
  always_ff @(posedge clk) begin
    days1 <= day_prod[DayShift +: DaysW];

    days2 <= days1;
    quad2 <= quad_prod[QuadShift +: 6];
    wk_t2 <= wk_t;
    wk_q2 <= wk_prod[WeekShift +: 15];

    quad3 <= quad2;
    qrem3 <= block_day[10:0];
    wd3   <= wk_rem[2:0];

    yr4   <= 12'(EpochYear) + 12'({quad3, yoff});
    doy4  <= doy_w[8:0];
    leap4 <= (yoff == LeapSlot);
    wd4   <= wd3;

    yr5   <= yr4;
    doy5  <= doy4;
    leap5 <= leap4;
    mon5  <= mon_w;
    wd5   <= wd4;

    if (v5) begin
      year         <= yr5;
      month        <= mon5;
      day_of_month <= dom_off[4:0] + 5'd1;
      weekday      <= wd5;
    end
  end

  `ESD_ASSERT_NEXT(a_valid_done, clk, rst, v5, done, "beat lost before done")
  `ESD_ASSERT_ALWAYS(a_done_month, clk, rst, !done || (month != 4'd0 && month <= 4'd12), "bad month")
  `ESD_ASSERT_ALWAYS(a_done_wd, clk, rst, !done || weekday <= 3'd6, "bad weekday")
endmodule
`default_nettype wire
